FILE: hw/rtl/ibfs_pkg.sv
`default_nettype none
package ibfs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int QONE      = 1 << FRAC_BITS;
  localparam int QHALF     = 1 << (FRAC_BITS - 1);
  localparam int PHI_W     = FRAC_BITS;
  localparam int SQ_W      = 2 * FRAC_BITS + 3;
  localparam int SQRT_STEPS = FRAC_BITS + 1;
  localparam int DIV3_MUL  = 174763;
  localparam int DIV3_SH   = 19;
  localparam int DIV3_IN_W = 20;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_VERTEX = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DY = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] value_u;
    logic signed [DATA_W-1:0] value_v;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] cell_u;
    logic signed [DATA_W-1:0] cell_v;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD, S_READ, S_READ_WAIT, S_NEAR, S_ROUND,
    S_PHI_DIST, S_PHI_SCALE, S_PHI_SQR, S_PHI_SQRT, S_PHI_FIN,
    S_P0_ADDR, S_P0_WGT, S_P0_MUL, S_P0_ACC, S_FORCE,
    S_P1_ADDR, S_P1_WGT, S_P1_MUL, S_P1_WR, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CAPTURE, OP_LOAD, OP_READ, OP_READ_TAKE, OP_NEAR, OP_ROUND,
    OP_PHI_DIST, OP_PHI_SCALE, OP_PHI_SQR, OP_PHI_SQRT, OP_PHI_FIN,
    OP_ADDR, OP_WGT, OP_MUL, OP_ACC, OP_FORCE, OP_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       pass;
    logic [1:0] sel;
    logic [1:0] a;
    logic [4:0] it;
    logic [1:0] ci;
    logic [1:0] cj;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

  // floor(x/3) by reciprocal, exact for x below 2^19
  function automatic logic [PHI_W-1:0] div3(input logic [DIV3_IN_W-1:0] x);
    logic [37:0] p;
    p = 38'(x) * 38'(DIV3_MUL);
    return PHI_W'(p >> DIV3_SH);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ibfs_ram.sv
`default_nettype none
module ibfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ibfs_dp.sv
`default_nettype none
module ibfs_dp
  import ibfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output out_t                 out_data
);

  localparam int ACC_W = 37;
  localparam int NUM_W = FRAC_BITS + 5;
  localparam int MP_W  = DATA_W + PHI_W + 1;
  localparam int R_W   = FRAC_BITS + 2;

  logic [CFG_W-1:0] dx_r, dy_r, inv_dx_r, inv_dy_r;
  in_t  in_r;
  out_t out_r;
  logic signed [63:0] prod_x_r, prod_y_r;
  logic signed [31:0] ni_r, nj_r;
  logic [31:0]        dm_r;
  logic               far_r;
  logic [R_W-1:0]     r_r;
  logic               lo_r;
  logic [SQ_W-1:0]    sq_n_r, sq_res_r;
  logic [PHI_W-1:0]   phi_r [4][3];
  logic [PHI_W-1:0]   w_u_r, w_v_r;
  logic signed [DATA_W-1:0] val_u_r, val_v_r;
  logic signed [MP_W-1:0]   mp_u_r, mp_v_r;
  logic signed [ACC_W-1:0]  su_r, sv_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r     <= CFG_W'(QONE);
      dy_r     <= CFG_W'(QONE);
      inv_dx_r <= CFG_W'(QONE);
      inv_dy_r <= CFG_W'(QONE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DX:     dx_r     <= cfg_data;
        CFG_DY:     dy_r     <= cfg_data;
        CFG_INV_DX: inv_dx_r <= cfg_data;
        CFG_INV_DY: inv_dy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // load/read address
  logic              ld_in;
  logic [ADDR_W-1:0] ld_addr;
  assign ld_in   = ({1'b0, in_r.row} < (ROW_W+1)'(GRID_ROWS)) &&
                   ({1'b0, in_r.col} < (COL_W+1)'(GRID_COLS));
  assign ld_addr = ADDR_W'(in_r.row) * ADDR_W'(GRID_COLS) + ADDR_W'(in_r.col);

  // nearest cell rounding
  function automatic logic signed [31:0] round_q(input logic signed [63:0] t);
    logic [63:0] m;
    logic [63:0] n;
    m = t[63] ? 64'(-t) : 64'(t);
    n = (m + (64'd1 << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
    return t[63] ? -$signed(32'(n)) : $signed(32'(n));
  endfunction

  // neighbour cell of the current walk
  logic [33:0]       ci_sum, cj_sum;
  logic              cell_ok;
  logic [ADDR_W-1:0] cell_addr;
  always_comb begin
    ci_sum    = 34'(ni_r) + 34'(cmd.ci) - 34'd1;
    cj_sum    = 34'(nj_r) + 34'(cmd.cj) - 34'd1;
    cell_ok   = !ci_sum[33] && (ci_sum < 34'(GRID_COLS)) &&
                !cj_sum[33] && (cj_sum < 34'(GRID_ROWS));
    cell_addr = ADDR_W'(cj_sum[ROW_W-1:0]) * ADDR_W'(GRID_COLS) +
                ADDR_W'(ci_sum[COL_W-1:0]);
  end

  // kernel distance
  logic                      half;
  logic signed [31:0]        p_base, p_pos;
  logic [33:0]               p_sum;
  logic [IDX_W-1:0]          p_idx;
  logic [CFG_W-1:0]          p_sp, p_inv;
  logic [CFG_W+IDX_W-1:0]    p_prod;
  logic signed [39:0]        p_sample, p_d;
  logic [39:0]               p_m;
  always_comb begin
    half     = (cmd.sel == 2'd0) || (cmd.sel == 2'd3);
    p_base   = cmd.sel[1] ? nj_r : ni_r;
    p_pos    = cmd.sel[1] ? in_r.pos_y : in_r.pos_x;
    p_sp     = cmd.sel[1] ? dy_r : dx_r;
    p_inv    = cmd.sel[1] ? inv_dy_r : inv_dx_r;
    p_sum    = 34'(p_base) + 34'(cmd.a) - 34'd1;
    p_idx    = p_sum[IDX_W-1:0];
    p_prod   = (CFG_W+IDX_W)'(p_idx) * (CFG_W+IDX_W)'(p_sp);
    p_sample = $signed(40'(p_prod)) - (half ? $signed(40'(p_sp >> 1)) : 40'sd0);
    p_d      = 40'(p_pos) - p_sample;
    p_m      = p_d[39] ? 40'(-p_d) : 40'(p_d);
  end

  // scale and square
  logic [62:0]     s_prod;
  logic [46:0]     s_r;
  logic            q_lo;
  logic [R_W-1:0]  q_e;
  logic [2*R_W-1:0] q_sq;
  logic [19:0]     q_t;
  logic [SQ_W-1:0] q_arg;
  always_comb begin
    s_prod = 63'(dm_r) * 63'(p_inv);
    s_r    = 47'(s_prod >> FRAC_BITS);
    q_lo   = r_r < R_W'(QHALF);
    q_e    = q_lo ? r_r : ((r_r >= R_W'(QONE)) ? r_r - R_W'(QONE) : R_W'(QONE) - r_r);
    q_sq   = (2*R_W)'(q_e) * (2*R_W)'(q_e);
    q_t    = 20'(q_sq >> FRAC_BITS);
    q_arg  = (SQ_W'(QONE) - SQ_W'(q_t) - SQ_W'({q_t, 1'b0})) << FRAC_BITS;
  end

  // square root step
  logic [5:0]      sq_sh;
  logic [SQ_W-1:0] sq_bit, sq_try;
  always_comb begin
    sq_sh  = {5'(SQRT_STEPS-1) - cmd.it, 1'b0};
    sq_bit = SQ_W'(1) << sq_sh;
    sq_try = sq_res_r + sq_bit;
  end

  // kernel value
  logic [R_W-1:0]       f_s;
  logic [DIV3_IN_W-1:0] f_lo_num;
  logic [NUM_W-1:0]     f_num;
  logic [PHI_W-1:0]     f_phi;
  always_comb begin
    f_s      = sq_res_r[R_W-1:0];
    f_lo_num = DIV3_IN_W'(QONE) + DIV3_IN_W'(f_s);
    f_num    = NUM_W'(5*QONE) - NUM_W'(r_r) * NUM_W'(3) - NUM_W'(f_s);
    if (far_r) begin
      f_phi = '0;
    end else if (lo_r) begin
      f_phi = div3(f_lo_num);
    end else if (!f_num[NUM_W-1] && (f_num != '0)) begin
      f_phi = div3(DIV3_IN_W'(f_num >> 1));
    end else begin
      f_phi = '0;
    end
  end

  // weights and products
  logic [2*PHI_W-1:0]       wg_u, wg_v;
  logic signed [DATA_W-1:0] m_u, m_v;
  logic signed [DATA_W-1:0] fx, fy, nu, nv;
  always_comb begin
    wg_u = (2*PHI_W)'(phi_r[0][cmd.ci]) * (2*PHI_W)'(phi_r[2][cmd.cj]);
    wg_v = (2*PHI_W)'(phi_r[1][cmd.ci]) * (2*PHI_W)'(phi_r[3][cmd.cj]);
    m_u  = cmd.pass ? out_r.force_x : val_u_r;
    m_v  = cmd.pass ? out_r.force_y : val_v_r;
    fx   = sat32(40'(in_r.value_u) - 40'(sat32(40'(su_r))));
    fy   = sat32(40'(in_r.value_v) - 40'(sat32(40'(sv_r))));
    nu   = sat32(40'(val_u_r) + 40'(mp_u_r >>> FRAC_BITS));
    nv   = sat32(40'(val_v_r) + 40'(mp_v_r >>> FRAC_BITS));
  end

  // grids
  logic                tent_we, corr_we;
  logic [ADDR_W-1:0]   corr_waddr, raddr;
  logic [2*DATA_W-1:0] corr_wdata, tent_rd, corr_rd;
  always_comb begin
    tent_we    = (cmd.op == OP_LOAD) && ld_in;
    corr_we    = tent_we || ((cmd.op == OP_WR) && cell_ok);
    corr_waddr = (cmd.op == OP_LOAD) ? ld_addr : cell_addr;
    corr_wdata = (cmd.op == OP_LOAD) ? {in_r.value_u, in_r.value_v} : {nu, nv};
    raddr      = (cmd.op == OP_READ) ? ld_addr : cell_addr;
  end

  ibfs_ram #(.WIDTH(2*DATA_W), .DEPTH(CELLS)) u_tent_ram (
    .clk   (clk),
    .we    (tent_we),
    .waddr (ld_addr),
    .wdata ({in_r.value_u, in_r.value_v}),
    .raddr (raddr),
    .rdata (tent_rd)
  );

  ibfs_ram #(.WIDTH(2*DATA_W), .DEPTH(CELLS)) u_corr_ram (
    .clk   (clk),
    .we    (corr_we),
    .waddr (corr_waddr),
    .wdata (corr_wdata),
    .raddr (raddr),
    .rdata (corr_rd)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        in_r  <= in_data;
        out_r <= '0;
        su_r  <= '0;
        sv_r  <= '0;
      end
      OP_READ_TAKE: begin
        if (ld_in) begin
          out_r.cell_u <= corr_rd[2*DATA_W-1:DATA_W];
          out_r.cell_v <= corr_rd[DATA_W-1:0];
        end
      end
      OP_NEAR: begin
        prod_x_r <= 64'(in_r.pos_x) * 64'($signed({1'b0, inv_dx_r}));
        prod_y_r <= 64'(in_r.pos_y) * 64'($signed({1'b0, inv_dy_r}));
      end
      OP_ROUND: begin
        ni_r <= round_q(prod_x_r);
        nj_r <= round_q(prod_y_r);
      end
      OP_PHI_DIST: begin
        dm_r  <= p_m[31:0];
        far_r <= |p_m[39:32];
      end
      OP_PHI_SCALE: begin
        r_r   <= s_r[R_W-1:0];
        far_r <= far_r || (s_r > 47'(3*QHALF));
      end
      OP_PHI_SQR: begin
        lo_r     <= q_lo;
        sq_n_r   <= q_arg;
        sq_res_r <= '0;
      end
      OP_PHI_SQRT: begin
        if (sq_n_r >= sq_try) begin
          sq_n_r   <= sq_n_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
      end
      OP_PHI_FIN: begin
        phi_r[cmd.sel][cmd.a] <= f_phi;
      end
      OP_WGT: begin
        w_u_r   <= PHI_W'(wg_u >> FRAC_BITS);
        w_v_r   <= PHI_W'(wg_v >> FRAC_BITS);
        val_u_r <= cmd.pass ? corr_rd[2*DATA_W-1:DATA_W] : tent_rd[2*DATA_W-1:DATA_W];
        val_v_r <= cmd.pass ? corr_rd[DATA_W-1:0] : tent_rd[DATA_W-1:0];
      end
      OP_MUL: begin
        mp_u_r <= MP_W'(m_u) * MP_W'($signed({1'b0, w_u_r}));
        mp_v_r <= MP_W'(m_v) * MP_W'($signed({1'b0, w_v_r}));
      end
      OP_ACC: begin
        if (cell_ok) begin
          su_r <= su_r + ACC_W'(mp_u_r >>> FRAC_BITS);
          sv_r <= sv_r + ACC_W'(mp_v_r >>> FRAC_BITS);
        end
      end
      OP_FORCE: begin
        out_r.force_x <= fx;
        out_r.force_y <= fy;
      end
      default: ;
    endcase
  end

  assign sts.func = in_r.func;
  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ibfs_ctrl.sv
`default_nettype none
module ibfs_ctrl
  import ibfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  ctl_state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt, a_r, a_nxt, ci_r, ci_nxt, cj_r, cj_nxt;
  logic [4:0] it_r, it_nxt;
  logic       phi_last, cell_last, sqrt_last;

  assign phi_last  = (sel_r == 2'd3) && (a_r == 2'd2);
  assign cell_last = (ci_r == 2'd2) && (cj_r == 2'd2);
  assign sqrt_last = (it_r == 5'(SQRT_STEPS-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
      a_r     <= '0;
      it_r    <= '0;
      ci_r    <= '0;
      cj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      a_r     <= a_nxt;
      it_r    <= it_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        case (sts.func)
          FUNC_LOAD:   state_nxt = S_LOAD;
          FUNC_READ:   state_nxt = S_READ;
          FUNC_VERTEX: state_nxt = S_NEAR;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_LOAD:      state_nxt = S_DONE;
      S_READ:      state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_DONE;
      S_NEAR:      state_nxt = S_ROUND;
      S_ROUND:     state_nxt = S_PHI_DIST;
      S_PHI_DIST:  state_nxt = S_PHI_SCALE;
      S_PHI_SCALE: state_nxt = S_PHI_SQR;
      S_PHI_SQR:   state_nxt = S_PHI_SQRT;
      S_PHI_SQRT:  if (sqrt_last) state_nxt = S_PHI_FIN;
      S_PHI_FIN:   state_nxt = phi_last ? S_P0_ADDR : S_PHI_DIST;
      S_P0_ADDR:   state_nxt = S_P0_WGT;
      S_P0_WGT:    state_nxt = S_P0_MUL;
      S_P0_MUL:    state_nxt = S_P0_ACC;
      S_P0_ACC:    state_nxt = cell_last ? S_FORCE : S_P0_ADDR;
      S_FORCE:     state_nxt = S_P1_ADDR;
      S_P1_ADDR:   state_nxt = S_P1_WGT;
      S_P1_WGT:    state_nxt = S_P1_MUL;
      S_P1_MUL:    state_nxt = S_P1_WR;
      S_P1_WR:     state_nxt = cell_last ? S_DONE : S_P1_ADDR;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    sel_nxt = sel_r;
    a_nxt   = a_r;
    it_nxt  = it_r;
    ci_nxt  = ci_r;
    cj_nxt  = cj_r;
    case (state_r)
      S_ROUND: begin
        sel_nxt = '0;
        a_nxt   = '0;
      end
      S_PHI_SQR:  it_nxt = '0;
      S_PHI_SQRT: it_nxt = it_r + 5'd1;
      S_PHI_FIN: begin
        if (a_r == 2'd2) begin
          a_nxt   = '0;
          sel_nxt = sel_r + 2'd1;
        end else begin
          a_nxt = a_r + 2'd1;
        end
        ci_nxt = '0;
        cj_nxt = '0;
      end
      S_P0_ACC, S_P1_WR: begin
        if (cj_r == 2'd2) begin
          cj_nxt = '0;
          ci_nxt = ci_r + 2'd1;
        end else begin
          cj_nxt = cj_r + 2'd1;
        end
      end
      S_FORCE: begin
        ci_nxt = '0;
        cj_nxt = '0;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = OP_IDLE;
    cmd.pass = 1'b0;
    cmd.sel  = sel_r;
    cmd.a    = a_r;
    cmd.it   = it_r;
    cmd.ci   = ci_r;
    cmd.cj   = cj_r;
    case (state_r)
      S_IDLE:      if (start) cmd.op = OP_CAPTURE;
      S_LOAD:      cmd.op = OP_LOAD;
      S_READ:      cmd.op = OP_READ;
      S_READ_WAIT: cmd.op = OP_READ_TAKE;
      S_NEAR:      cmd.op = OP_NEAR;
      S_ROUND:     cmd.op = OP_ROUND;
      S_PHI_DIST:  cmd.op = OP_PHI_DIST;
      S_PHI_SCALE: cmd.op = OP_PHI_SCALE;
      S_PHI_SQR:   cmd.op = OP_PHI_SQR;
      S_PHI_SQRT:  cmd.op = OP_PHI_SQRT;
      S_PHI_FIN:   cmd.op = OP_PHI_FIN;
      S_P0_ADDR:   cmd.op = OP_ADDR;
      S_P0_WGT:    cmd.op = OP_WGT;
      S_P0_MUL:    cmd.op = OP_MUL;
      S_P0_ACC:    cmd.op = OP_ACC;
      S_FORCE:     cmd.op = OP_FORCE;
      S_P1_ADDR: begin
        cmd.op   = OP_ADDR;
        cmd.pass = 1'b1;
      end
      S_P1_WGT: begin
        cmd.op   = OP_WGT;
        cmd.pass = 1'b1;
      end
      S_P1_MUL: begin
        cmd.op   = OP_MUL;
        cmd.pass = 1'b1;
      end
      S_P1_WR: begin
        cmd.op   = OP_WR;
        cmd.pass = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

`ifndef SYNTHESIS
  ast_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DECODE))
    else $error("accepted transfer did not enter decode");

  ast_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block stayed busy after result");

  ast_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PHI_SQRT) |-> (it_r < 5'(SQRT_STEPS)))
    else $error("square root step count overran");

  ast_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P0_ACC || state_r == S_P1_WR) |-> (ci_r != 2'd3 && cj_r != 2'd3))
    else $error("neighbour walk left the 3x3 window");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/immersed_boundary_force_step_core.sv
`default_nettype none
// a vertex runs 12 kernel evaluations on one shared kernel unit
// (each with a bit-serial square root), then two walks over 3x3 cells
// next item accepted the cycle after the strobe; no new item is taken while busy
// result strobe lasts one cycle and cannot be stalled
// synchronous active-low reset clears control and config; grid contents stay undefined
module immersed_boundary_force_step_core
  import ibfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ibfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ibfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
